// ===== rtl/sirdig_pkg.sv =====
package sirdig_pkg;

  localparam int MAX_DIGITS_DEF = 16;
  localparam int VALUE_BITS_DEF = 32;
  localparam int ALPHA_CHARS    = 16;
  localparam int CHAR_BITS      = 8;
  // quotient bits resolved per divider cycle
  localparam int DIV_STEP       = 4;

  localparam logic [CHAR_BITS-1:0] PLUS_CHAR  = 8'h2B;
  localparam logic [CHAR_BITS-1:0] MINUS_CHAR = 8'h2D;

  localparam logic [4:0]  BASE_LENGTH_RST = 5'd10;
  localparam logic [63:0] DIGITS_LOW_RST  = 64'h3736_3534_3332_3130;
  localparam logic [63:0] DIGITS_HIGH_RST = 64'h0000_0000_0000_3938;

  typedef enum logic [1:0] {
    CFG_BASE_LENGTH = 2'd0,
    CFG_DIGITS_LOW  = 2'd1,
    CFG_DIGITS_HIGH = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_DIV,
    S_EMIT,
    S_ERR
  } state_t;

  typedef struct packed {
    logic       start;
    logic [4:0] radix;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic quot_zero;
  } div_stat_t;

  function automatic logic [CHAR_BITS-1:0] alpha_char(
    input logic [ALPHA_CHARS*CHAR_BITS-1:0] alpha,
    input logic [3:0]                       idx
  );
    return alpha[{idx, 3'b000} +: CHAR_BITS];
  endfunction

endpackage

// ===== rtl/signed_int_to_custom_radix_digits_unit.sv =====
// Signed integer to text in a radix given by a programmable digit alphabet.
// Input stream: in_tdata carries one signed value per word; its low
// VALUE_BITS bits are used. Output stream: one character per word, most
// significant digit first, a leading '-' for negative values, out_tlast on
// the final character of each value. If the alphabet is invalid (length out
// of 2..MAX_DIGITS, a zero byte, '+', '-' or a repeated character) a single
// word with out_tuser set, out_tdata zero and out_tlast high is sent.
// Config: cfg_we with cfg_index 0 = base_length, 1 = digits_low,
// 2 = digits_high; write only while idle.
// Timing: one value at a time. in_tready is high only when idle. After the
// accept the sequencer passes through a setup state, then each digit is
// produced by the shared divider (4 quotient bits per cycle), then the text is
// sent at one character per cycle while out_tready is high. A stalled receiver
// holds the current character; nothing is lost.
// Reset (synchronous, rst_n low) restores the decimal alphabet "0123456789"
// and returns the sequencer to idle, dropping any value in progress.
module signed_int_to_custom_radix_digits_unit #(
  parameter int MAX_DIGITS = sirdig_pkg::MAX_DIGITS_DEF,
  parameter int VALUE_BITS = sirdig_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [31:0] value
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  // out_tdata: [7:0] character
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,
  output logic        out_tlast,
  // out_tuser: [0] base_error
  output logic        out_tuser,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam int IW = $clog2(VALUE_BITS);
  localparam int CW = $clog2(VALUE_BITS + 1);

  sirdig_pkg::state_t    state_r, state_nxt;
  sirdig_pkg::div_req_t  div_req;
  sirdig_pkg::div_stat_t div_stat;

  logic [4:0]            base_length_r;
  logic [63:0]           digits_low_r, digits_high_r;
  logic [127:0]          alphabet;
  logic                  alpha_ok;

  logic [VALUE_BITS-1:0] mag_r, mag_nxt, raw, div_dividend, div_quot;
  logic [3:0]            div_rem;
  logic                  neg_r, neg_nxt;
  logic                  sign_pend_r, sign_pend_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [IW-1:0]         rd_idx;
  logic [3:0]            digs_r [VALUE_BITS];
  logic                  in_acc, out_acc;

  assign alphabet = {digits_high_r, digits_low_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_length_r <= sirdig_pkg::BASE_LENGTH_RST;
      digits_low_r  <= sirdig_pkg::DIGITS_LOW_RST;
      digits_high_r <= sirdig_pkg::DIGITS_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sirdig_pkg::CFG_BASE_LENGTH: base_length_r <= cfg_wdata[4:0];
        sirdig_pkg::CFG_DIGITS_LOW:  digits_low_r  <= cfg_wdata;
        sirdig_pkg::CFG_DIGITS_HIGH: digits_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  sirdig_alpha_check #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .base_length(base_length_r),
    .alphabet   (alphabet),
    .alpha_ok   (alpha_ok)
  );

  sirdig_divider #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dividend),
    .quotient (div_quot),
    .remainder(div_rem),
    .stat     (div_stat)
  );

  assign raw     = in_tdata[VALUE_BITS-1:0];
  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign rd_idx  = IW'(cnt_r - CW'(1));

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    sign_pend_nxt = sign_pend_r;
    cnt_nxt       = cnt_r;
    div_req.start = 1'b0;
    div_req.radix = base_length_r;
    div_dividend  = (state_r == sirdig_pkg::S_SETUP) ? mag_r : div_quot;
    unique case (state_r)
      sirdig_pkg::S_IDLE: begin
        if (in_acc) begin
          neg_nxt   = raw[VALUE_BITS-1];
          // two's complement magnitude; the most negative value maps to 2^(N-1)
          mag_nxt   = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
          cnt_nxt   = '0;
          state_nxt = sirdig_pkg::S_SETUP;
        end
      end
      sirdig_pkg::S_SETUP: begin
        if (alpha_ok) begin
          div_req.start = 1'b1;
          state_nxt     = sirdig_pkg::S_DIV;
        end else begin
          state_nxt = sirdig_pkg::S_ERR;
        end
      end
      sirdig_pkg::S_DIV: begin
        if (div_stat.done) begin
          cnt_nxt = cnt_r + CW'(1);
          if (div_stat.quot_zero) begin
            sign_pend_nxt = neg_r;
            state_nxt     = sirdig_pkg::S_EMIT;
          end else begin
            div_req.start = 1'b1;
          end
        end
      end
      sirdig_pkg::S_EMIT: begin
        if (out_acc) begin
          if (sign_pend_r) begin
            sign_pend_nxt = 1'b0;
          end else begin
            cnt_nxt = cnt_r - CW'(1);
            if (cnt_r == CW'(1)) state_nxt = sirdig_pkg::S_IDLE;
          end
        end
      end
      sirdig_pkg::S_ERR: begin
        if (out_acc) state_nxt = sirdig_pkg::S_IDLE;
      end
      default: state_nxt = sirdig_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sirdig_pkg::S_IDLE;
      sign_pend_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      sign_pend_r <= sign_pend_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
  end

  // digit buffer, least significant digit at index 0
  always_ff @(posedge clk) begin
    if (state_r == sirdig_pkg::S_DIV && div_stat.done)
      digs_r[cnt_r[IW-1:0]] <= div_rem;
  end

  assign in_tready  = (state_r == sirdig_pkg::S_IDLE);
  assign out_tvalid = (state_r == sirdig_pkg::S_EMIT) || (state_r == sirdig_pkg::S_ERR);
  assign out_tuser  = (state_r == sirdig_pkg::S_ERR);

  always_comb begin
    if (state_r == sirdig_pkg::S_ERR) begin
      out_tdata = '0;
      out_tlast = 1'b1;
    end else if (sign_pend_r) begin
      out_tdata = sirdig_pkg::MINUS_CHAR;
      out_tlast = 1'b0;
    end else begin
      out_tdata = sirdig_pkg::alpha_char(alphabet, digs_r[rd_idx]);
      out_tlast = (cnt_r == CW'(1));
    end
  end

endmodule

// ===== rtl/sirdig_divider.sv =====
module sirdig_divider #(
  parameter int VALUE_BITS = sirdig_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sirdig_pkg::div_req_t  req,
  input  logic [VALUE_BITS-1:0] dividend,
  output logic [VALUE_BITS-1:0] quotient,
  output logic [3:0]            remainder,
  output sirdig_pkg::div_stat_t stat
);

  localparam int STEP = sirdig_pkg::DIV_STEP;
  localparam int DW   = ((VALUE_BITS + STEP - 1) / STEP) * STEP;
  localparam int NCYC = DW / STEP;
  localparam int CNTW = $clog2(NCYC + 1);

  logic [DW-1:0]   work_r, work_nxt;
  logic [3:0]      rem_r, rem_nxt;
  logic [4:0]      radix_r;
  logic [4:0]      trial;
  logic [CNTW-1:0] cnt_r;
  logic            done_r;

  // restoring division, quotient bits shift in at the bottom of work_r
  always_comb begin
    work_nxt = work_r;
    rem_nxt  = rem_r;
    trial    = '0;
    for (int k = 0; k < STEP; k++) begin
      trial    = {rem_nxt, work_nxt[DW-1]};
      work_nxt = {work_nxt[DW-2:0], 1'b0};
      if (trial >= radix_r) begin
        trial       = trial - radix_r;
        work_nxt[0] = 1'b1;
      end
      rem_nxt = trial[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r <= CNTW'(NCYC);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      work_r  <= DW'(dividend);
      rem_r   <= '0;
      radix_r <= req.radix;
    end else if (cnt_r != '0) begin
      work_r <= work_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign quotient       = work_r[VALUE_BITS-1:0];
  assign remainder      = rem_r;
  assign stat.done      = done_r;
  assign stat.quot_zero = (work_r == '0);

endmodule

// ===== rtl/sirdig_alpha_check.sv =====
module sirdig_alpha_check #(
  parameter int MAX_DIGITS = sirdig_pkg::MAX_DIGITS_DEF
) (
  input  logic                                                  clk,
  input  logic                                                  rst_n,
  input  logic [4:0]                                            base_length,
  input  logic [sirdig_pkg::ALPHA_CHARS*sirdig_pkg::CHAR_BITS-1:0] alphabet,
  output logic                                                  alpha_ok
);

  logic                            alpha_ok_r, alpha_ok_nxt;
  logic [sirdig_pkg::CHAR_BITS-1:0] ci;

  always_comb begin
    alpha_ok_nxt = (base_length >= 5'd2) && (base_length <= 5'(MAX_DIGITS));
    ci           = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      ci = sirdig_pkg::alpha_char(alphabet, 4'(i));
      if (5'(i) < base_length) begin
        if (ci == '0 || ci == sirdig_pkg::PLUS_CHAR || ci == sirdig_pkg::MINUS_CHAR)
          alpha_ok_nxt = 1'b0;
        for (int j = i + 1; j < MAX_DIGITS; j++) begin
          if (5'(j) < base_length && sirdig_pkg::alpha_char(alphabet, 4'(j)) == ci)
            alpha_ok_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_ok_r <= 1'b0;
    end else begin
      alpha_ok_r <= alpha_ok_nxt;
    end
  end

  assign alpha_ok = alpha_ok_r;

endmodule

// ===== rtl/sirdig_checker.sv =====
module sirdig_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  // one value in flight: never taking input while text is going out
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while output valid");

  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == 8'h00))
    else $error("base error word malformed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after accept");

  // characters of one value go out back to back
  a_text_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && !out_tuser)
    else $error("gap inside value text");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled word changed");

endmodule

bind signed_int_to_custom_radix_digits_unit sirdig_checker u_sirdig_checker (.*);
